### rtl/mcc_pkg.sv
// ============================================================================
// mcc_pkg
// Shared types, request codes and the CRC-32 byte fold for the multi-context
// CRC-32 engine.
// ============================================================================
package mcc_pkg;

   localparam int unsigned CrcWidth  = 32;
   localparam int unsigned IdxWidth  = 4;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned KindWidth = 2;

   localparam logic [CrcWidth-1:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Request kinds carried on req_tuser. The fourth code is a no-op.
   localparam logic [KindWidth-1:0] REQ_OPEN  = 2'd0;
   localparam logic [KindWidth-1:0] REQ_PUSH  = 2'd1;
   localparam logic [KindWidth-1:0] REQ_CLOSE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted item and start the context read
      logic exec;      // apply the latched item to the context state
   } mcc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_close;  // the latched item is a close request
      logic out_free;  // the result register can take a new item this cycle
   } mcc_stat_type;

   // Folds one byte into a reflected CRC-32 running value, LSB first.
   function automatic logic [CrcWidth-1:0] fold_byte(
      input logic [CrcWidth-1:0]  crc,
      input logic [ByteWidth-1:0] data
   );
      logic [CrcWidth-1:0] v;
      v = {24'd0, crc[7:0] ^ data};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v ^ {8'd0, crc[CrcWidth-1:8]};
   endfunction

endpackage

### rtl/mcc_ctrl.sv
// ============================================================================
// mcc_ctrl
// Controller for the CRC engine: takes one item, lets the datapath read the
// context, then applies it, a close only once the result register has room.
// ============================================================================
module mcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mcc_pkg::mcc_stat_type stat,
   output mcc_pkg::mcc_cmd_type  cmd
);
   import mcc_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;
   logic      exec;

   assign accept = req_tvalid && ready_ff;
   // A close waits here until the previous result has been taken.
   assign exec   = (state_ff == ST_EXEC) && (!stat.is_close || stat.out_free);

   assign cmd.capture = accept;
   assign cmd.exec    = exec;
   assign req_tready  = ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               if (exec) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

### rtl/mcc_dpath.sv
// ============================================================================
// mcc_dpath
// Datapath for the CRC engine: context memory, live bits, byte fold and the
// result register.
// ============================================================================
module mcc_dpath #(
   parameter int unsigned NUM_CONTEXTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mcc_pkg::mcc_cmd_type                 cmd,
   output mcc_pkg::mcc_stat_type                stat,
   input  logic [mcc_pkg::KindWidth-1:0]        req_kind,
   input  logic [mcc_pkg::IdxWidth-1:0]         req_index,
   input  logic [mcc_pkg::ByteWidth-1:0]        req_byte,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mcc_pkg::CrcWidth-1:0]         rsp_crc,
   output logic                                rsp_found
);
   import mcc_pkg::*;

   localparam int unsigned AddrW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

   logic [CrcWidth-1:0]  crc_mem [NUM_CONTEXTS];
   logic [NUM_CONTEXTS-1:0] live_ff;

   logic [KindWidth-1:0] kind_ff;
   logic [IdxWidth-1:0]  index_ff;
   logic [ByteWidth-1:0] byte_ff;
   logic [CrcWidth-1:0]  rd_data_ff;

   logic                 rsp_valid_ff;
   logic [CrcWidth-1:0]  rsp_crc_ff;
   logic                 rsp_found_ff;

   logic [8:0]           rd_index_ext;
   logic [8:0]           index_ext;
   logic [AddrW-1:0]     rd_addr;
   logic [AddrW-1:0]     addr;
   logic                 in_range;
   logic                 live_hit;
   logic                 mem_we;
   logic [CrcWidth-1:0]  mem_wdata;
   logic                 out_load;

   assign rd_index_ext = 9'(req_index);
   assign rd_addr      = rd_index_ext[AddrW-1:0];
   assign index_ext    = 9'(index_ff);
   assign addr         = index_ext[AddrW-1:0];
   assign in_range     = index_ext < 9'(NUM_CONTEXTS);
   assign live_hit     = in_range && live_ff[addr];

   assign stat.is_close = (kind_ff == REQ_CLOSE);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = CRC_ALL_ONES;
      case (kind_ff)
         REQ_OPEN: begin
            mem_we    = cmd.exec && in_range;
            mem_wdata = CRC_ALL_ONES;
         end
         REQ_PUSH: begin
            mem_we    = cmd.exec && live_hit;
            mem_wdata = fold_byte(rd_data_ff, byte_ff);
         end
         default: begin
            mem_we    = 1'b0;
            mem_wdata = CRC_ALL_ONES;
         end
      endcase
   end

   assign out_load = cmd.exec && stat.is_close;

   // Item latch and context memory. The read is issued as the item is taken.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         index_ff   <= req_index;
         byte_ff    <= req_byte;
         rd_data_ff <= crc_mem[rd_addr];
      end
      if (mem_we) begin
         crc_mem[addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (cmd.exec) begin
         if (kind_ff == REQ_OPEN && in_range) begin
            live_ff[addr] <= 1'b1;
         end else if (kind_ff == REQ_CLOSE && live_hit) begin
            live_ff[addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_crc_ff   <= live_hit ? ~rd_data_ff : '0;
         rsp_found_ff <= live_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_crc    = rsp_crc_ff;
   assign rsp_found  = rsp_found_ff;

endmodule

### rtl/multi_context_crc32_engine.sv
// ============================================================================
// multi_context_crc32_engine
// Independent reflected CRC-32 contexts that are opened, fed one byte at a
// time and closed to read the final value.
// ============================================================================
//
//   channel  | direction | tdata                           | tuser
//   ---------+-----------+---------------------------------+----------------
//   req_     | in        | [3:0] context_index, [11:4] byte | [1:0] req_type
//   rsp_     | out       | [31:0] crc_value                | [0] found
//
// Each item is latched while the context memory is read, and is then applied
// to the context in the controller's ST_EXEC state. A close also waits there
// until the result register is free. Reset clears all live bits; the context
// memory is not cleared. A result stays on rsp_ until it is taken, while the
// following open and push items proceed.
//
module multi_context_crc32_engine #(
   parameter int unsigned NUM_CONTEXTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] context_index, [11:4] data_byte, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] crc_value
   output logic [0:0]  rsp_tuser    // [0] found
);
   import mcc_pkg::*;

   mcc_cmd_type  cmd;
   mcc_stat_type stat;
   logic         rsp_found;

   mcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mcc_dpath #(
      .NUM_CONTEXTS (NUM_CONTEXTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser),
      .req_index  (req_tdata[3:0]),
      .req_byte   (req_tdata[11:4]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_crc    (rsp_tdata),
      .rsp_found  (rsp_found)
   );

   assign rsp_tuser = rsp_found;

`ifndef SYNTH
   // An item is applied only after it has been latched, never while taking one.
   assert property (@(posedge clock) disable iff (reset) !(cmd.capture && cmd.exec))
      else $error("item applied while a new item is taken");

   // Only one item is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken before the first was applied");

   // A new result appears only right after a close has been applied.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.exec && stat.is_close))
      else $error("result without a close request");

   // A close of a context that was not live reports zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("nonzero CRC reported for a context that was not live");
`endif

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: multi-context CRC-32 engine testbench
// Drives open, push, close and no-op items into the engine in random bursts,
// stalls the result side on a changing pattern, and checks every returned CRC
// and found flag against a predictor that tracks all sixteen contexts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import mcc_pkg::*;

   localparam int unsigned NumCtx = 16;
   // The fourth request code does nothing in the engine.
   localparam logic [KindWidth-1:0] REQ_NOP = 2'd3;

   typedef struct packed {
      logic [CrcWidth-1:0] crc;
      logic                found;
   } close_result_type;

   class crc_scoreboard;
      logic [CrcWidth-1:0] running_crc [NumCtx];
      bit                  ctx_live    [NumCtx];
      close_result_type    close_q[$];
      int unsigned         error_count;

      function new();
         foreach (ctx_live[i]) begin
            ctx_live[i]    = 1'b0;
            running_crc[i] = '0;
         end
         error_count = 0;
      endfunction

      // Bitwise reflected CRC-32 update, least significant data bit first.
      static function logic [CrcWidth-1:0] crc_fold(logic [CrcWidth-1:0] crc,
                                                    logic [ByteWidth-1:0] b);
         logic [CrcWidth-1:0] r;
         r = crc;
         for (int i = 0; i < ByteWidth; i++) begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : '0);
         end
         return r;
      endfunction

      function bit is_live(int unsigned idx);
         return ctx_live[idx];
      endfunction

      function int unsigned pending();
         return close_q.size();
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         error_count++;
      endtask

      task note_request(logic [KindWidth-1:0] kind, logic [IdxWidth-1:0] idx,
                        logic [ByteWidth-1:0] b);
         close_result_type res;
         case (kind)
            REQ_OPEN: begin
               running_crc[idx] = CRC_ALL_ONES;
               ctx_live[idx]    = 1'b1;
            end
            REQ_PUSH: begin
               if (ctx_live[idx]) running_crc[idx] = crc_fold(running_crc[idx], b);
            end
            REQ_CLOSE: begin
               if (ctx_live[idx]) begin
                  res.crc   = running_crc[idx] ^ CRC_ALL_ONES;
                  res.found = 1'b1;
                  ctx_live[idx] = 1'b0;
               end else begin
                  res.crc   = '0;
                  res.found = 1'b0;
               end
               close_q.push_back(res);
            end
            default: ;
         endcase
      endtask

      task check_response(logic [CrcWidth-1:0] crc, logic found);
         close_result_type want;
         if (close_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item crc %h found %b", crc, found));
         end else begin
            want = close_q.pop_front();
            if (crc !== want.crc)
               report_mismatch($sformatf("crc %h, expected %h", crc, want.crc));
            if (found !== want.found)
               report_mismatch($sformatf("found %b, expected %b", found, want.found));
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [3:0] context_index, [11:4] data_byte, [15:12] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] crc_value
   logic [0:0]  rsp_tuser;         // [0] found

   crc_scoreboard crc_board = new();

   int unsigned burst_left = 0;
   int unsigned rx_mode    = 0;
   int unsigned rx_stretch = 0;

   multi_context_crc32_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Result side: check taken items, then pick the next ready value from a
   // mode that is redrawn at random once its stretch runs out.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         crc_board.check_response(rsp_tdata, rsp_tuser[0]);
      if (rx_stretch == 0) begin
         rx_mode    = $urandom_range(0, 2);
         rx_stretch = $urandom_range(10, 80);
      end else begin
         rx_stretch--;
      end
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   task automatic idle_sender(int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Called right after a rising edge; returns at the edge that took the item.
   task automatic issue(logic [KindWidth-1:0] kind, logic [IdxWidth-1:0] idx,
                        logic [ByteWidth-1:0] b);
      if (burst_left == 0) begin
         idle_sender($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'd0, b, idx};
      do @(posedge clock); while (!req_tready);
      crc_board.note_request(kind, idx, b);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (crc_board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      string                check_msg;
      int unsigned          counted;
      int unsigned          roll;
      logic [IdxWidth-1:0]  idx;
      logic [KindWidth-1:0] kind;
      logic [ByteWidth-1:0] b;

      check_msg = "123456789";
      counted   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Close and push on never-opened contexts, a no-op, and a double close.
      issue(REQ_CLOSE, 4'd7, 8'h00);
      issue(REQ_PUSH, 4'd9, 8'hA5);
      issue(REQ_NOP, 4'd4, 8'h3C);
      issue(REQ_OPEN, 4'd0, 8'h00);
      issue(REQ_PUSH, 4'd0, 8'h00);
      issue(REQ_PUSH, 4'd0, 8'hFF);
      issue(REQ_CLOSE, 4'd0, 8'h00);
      issue(REQ_CLOSE, 4'd0, 8'h00);
      // Reopening a live context restarts it; the check string then gives
      // the well-known CRC-32 value.
      issue(REQ_OPEN, 4'd15, 8'h00);
      issue(REQ_PUSH, 4'd15, 8'hAA);
      issue(REQ_OPEN, 4'd15, 8'hFF);
      for (int i = 0; i < check_msg.len(); i++) issue(REQ_PUSH, 4'd15, check_msg[i]);
      issue(REQ_CLOSE, 4'd15, 8'h00);
      // Four bytes of all ones after the preset drive the running value to
      // zero, which must still count as live.
      issue(REQ_OPEN, 4'd3, 8'h00);
      repeat (4) issue(REQ_PUSH, 4'd3, 8'hFF);
      issue(REQ_CLOSE, 4'd3, 8'h00);

      // Mostly open, push, close runs interleaved across contexts, with some pushes
      // to closed contexts, stray closes, reopens of live contexts and no-ops.
      while (counted < 850) begin
         idx  = IdxWidth'($urandom_range(0, NumCtx - 1));
         b    = ByteWidth'($urandom_range(0, 255));
         roll = $urandom_range(0, 99);
         if (roll < 4)
            kind = REQ_NOP;
         else if (crc_board.is_live(idx))
            kind = (roll < 74) ? REQ_PUSH : (roll < 90) ? REQ_CLOSE : REQ_OPEN;
         else
            kind = (roll < 76) ? REQ_OPEN : (roll < 88) ? REQ_PUSH : REQ_CLOSE;
         counted++;
         issue(kind, idx, b);
         if (counted == 300 || counted == 600) begin
            wait_for_drain();
            counted++;
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (crc_board.error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("tb failed");
      $finish;
   end

endmodule
